@@ sv/strmi_pkg.sv @@
// Shared types, widths and a helper function for the range-minimum position block.
package strmi_pkg;

    localparam int PosW   = 10;
    localparam int ValW   = 32;
    localparam int LevelW = 5;
    localparam int DefMaxElements = 1024;
    localparam int DefTableLevels = 11;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // One classified item as it travels from the front end to the execution unit.
    typedef struct packed {
        t_cmd                    cmd;
        logic signed [ValW-1:0]  value;
        logic                    last;
        logic [PosW-1:0]         lo;
        logic [PosW-1:0]         hi;
        logic [PosW-1:0]         b_start;
        logic [LevelW-1:0]       level;
    } t_item;

    function automatic logic [LevelW-1:0] floor_log2(input logic [PosW:0] x);
        logic [LevelW-1:0] r;
        r = '0;
        for (int i = 0; i <= PosW; i++) begin
            if (x[i]) begin
                r = LevelW'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ sv/strmi_ram.sv @@
// Generic single-write, dual-read memory with registered read data.
module strmi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;
endmodule

@@ sv/strmi_front.sv @@
// Front end: accepts stream items, orders query ends, picks the level and queues the item.
module strmi_front
    import strmi_pkg::*;
#(
    parameter int TABLE_LEVELS = DefTableLevels
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [55:0]   i_s_tdata,
    input  logic          i_s_tuser,
    input  logic          i_s_tlast,
    input  logic          i_pop,
    output logic          o_item_valid,
    output t_item         o_item
);
    t_item            r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_fill;
    logic [1:0]       n_fill;
    t_item            w_item;
    logic [PosW-1:0]  w_a;
    logic [PosW-1:0]  w_b;
    logic [PosW-1:0]  w_lo;
    logic [PosW-1:0]  w_hi;
    logic [PosW:0]    w_len;
    logic [LevelW-1:0] w_lvl;
    logic             w_push;
    logic             w_pop;

    assign w_a   = i_s_tdata[41:32];
    assign w_b   = i_s_tdata[51:42];
    assign w_lo  = (w_a > w_b) ? w_b : w_a;
    assign w_hi  = (w_a > w_b) ? w_a : w_b;
    assign w_len = {1'b0, w_hi} - {1'b0, w_lo} + (PosW+1)'(1);

    always_comb begin
        w_lvl = floor_log2(w_len);
        if (int'(w_lvl) > TABLE_LEVELS - 1) begin
            w_lvl = LevelW'(TABLE_LEVELS - 1);
        end
        w_item.cmd     = t_cmd'(i_s_tuser);
        w_item.value   = i_s_tdata[31:0];
        w_item.last    = i_s_tlast;
        w_item.lo      = w_lo;
        w_item.hi      = w_hi;
        w_item.level   = w_lvl;
        w_item.b_start = PosW'({1'b0, w_hi} + (PosW+1)'(1) - ((PosW+1)'(1) << w_lvl));
    end

    assign o_s_tready   = (r_fill != 2'd2);
    assign w_push       = i_s_tvalid && o_s_tready;
    assign o_item_valid = (r_fill != 2'd0);
    assign o_item       = r_q[r_rd_ptr];
    assign w_pop        = i_pop && o_item_valid;

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end
endmodule

@@ sv/strmi_back.sv @@
// Execution unit: stores elements, builds the sparse table and answers queries.
module strmi_back
    import strmi_pkg::*;
#(
    parameter int MAX_ELEMENTS = DefMaxElements,
    parameter int TABLE_LEVELS = DefTableLevels
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_item_valid,
    input  t_item         i_item,
    output logic          o_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [15:0]   o_m_tdata,
    output logic          o_m_tuser
);
    localparam int AW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);
    localparam int TD  = TABLE_LEVELS * MAX_ELEMENTS;
    localparam int TAW = $clog2(TD);
    localparam int WW  = CW + PosW;

    typedef enum logic [2:0] {
        S_IDLE, S_LVL0, S_BRD, S_BEL, S_BWR, S_QRD, S_QEL, S_QOUT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic               r_ready;
    logic [CW-1:0]      r_i;
    logic [CW:0]        r_span;
    logic [LevelW-1:0]  r_lvl;
    logic [AW-1:0]      r_a;
    logic [AW-1:0]      r_b;
    logic               r_err;
    logic               r_m_valid;
    logic [PosW-1:0]    r_m_pos;
    logic               r_m_err;
    t_item              r_item;

    logic               w_e_we;
    logic [AW-1:0]      w_e_waddr;
    logic               w_e_re;
    logic [AW-1:0]      w_e_ra0;
    logic [AW-1:0]      w_e_ra1;
    logic [ValW-1:0]    w_e_rd0;
    logic [ValW-1:0]    w_e_rd1;
    logic               w_t_we;
    logic [TAW-1:0]     w_t_waddr;
    logic [AW-1:0]      w_t_wdata;
    logic               w_t_re;
    logic [TAW-1:0]     w_t_ra0;
    logic [TAW-1:0]     w_t_ra1;
    logic [AW-1:0]      w_t_rd0;
    logic [AW-1:0]      w_t_rd1;
    logic [AW-1:0]      w_pick;
    logic [CW-1:0]      w_idx;
    logic               w_q_err;
    logic [WW-1:0]      w_hi_w;
    logic [WW-1:0]      w_cnt_w;
    logic [WW-1:0]      w_lo_w;
    logic [WW-1:0]      w_bs_w;
    logic [WW-1:0]      w_pick_w;
    logic [WW-1:0]      w_i_w;
    logic [CW:0]        w_nspan;
    logic               w_out_free;

    function automatic logic [TAW-1:0] taddr(input logic [LevelW-1:0] lvl,
                                              input logic [WW-1:0] pos);
        logic [TAW+WW-1:0] s;
        s = (TAW+WW)'(lvl) * (TAW+WW)'(MAX_ELEMENTS) + (TAW+WW)'(pos);
        return s[TAW-1:0];
    endfunction

    strmi_ram #(.WIDTH(ValW), .DEPTH(MAX_ELEMENTS)) u_elem (
        .i_clk(i_clk), .i_we(w_e_we), .i_waddr(w_e_waddr), .i_wdata(i_item.value),
        .i_re(w_e_re), .i_raddr0(w_e_ra0), .i_raddr1(w_e_ra1),
        .o_rdata0(w_e_rd0), .o_rdata1(w_e_rd1)
    );

    strmi_ram #(.WIDTH(AW), .DEPTH(TD)) u_table (
        .i_clk(i_clk), .i_we(w_t_we), .i_waddr(w_t_waddr), .i_wdata(w_t_wdata),
        .i_re(w_t_re), .i_raddr0(w_t_ra0), .i_raddr1(w_t_ra1),
        .o_rdata0(w_t_rd0), .o_rdata1(w_t_rd1)
    );

    assign w_out_free = !r_m_valid || i_m_tready;
    assign o_pop      = (r_state == S_IDLE);
    assign w_idx      = r_ready ? '0 : r_cnt;
    assign w_hi_w     = WW'(i_item.hi);
    assign w_cnt_w    = WW'(r_cnt);
    assign w_q_err    = !r_ready || (w_hi_w >= w_cnt_w);
    assign w_lo_w     = WW'(r_item.lo);
    assign w_bs_w     = WW'(r_item.b_start);
    assign w_i_w      = WW'(r_i);
    assign w_nspan    = r_span << 1;
    // Equal values keep the second candidate.
    assign w_pick     = ($signed(w_e_rd0) < $signed(w_e_rd1)) ? r_a : r_b;
    assign w_pick_w   = WW'(w_pick);

    always_comb begin
        w_e_we    = 1'b0;
        w_e_waddr = w_idx[AW-1:0];
        w_e_re    = 1'b0;
        w_e_ra0   = w_t_rd0;
        w_e_ra1   = w_t_rd1;
        w_t_we    = 1'b0;
        w_t_waddr = taddr(r_lvl, w_i_w);
        w_t_wdata = r_i[AW-1:0];
        w_t_re    = 1'b0;
        w_t_ra0   = taddr(r_lvl - LevelW'(1), w_i_w);
        w_t_ra1   = taddr(r_lvl - LevelW'(1), w_i_w + WW'(r_span >> 1));
        case (r_state)
            S_IDLE: begin
                w_e_we = i_item_valid && (i_item.cmd == CMD_LOAD)
                         && (w_idx < CW'(MAX_ELEMENTS));
                w_e_waddr = w_idx[AW-1:0];
            end
            S_LVL0: begin
                w_t_we = 1'b1;
            end
            S_BRD: begin
                w_t_re = 1'b1;
            end
            S_BEL: begin
                w_e_re = 1'b1;
            end
            S_BWR: begin
                w_t_we    = 1'b1;
                w_t_wdata = w_pick;
            end
            S_QRD: begin
                w_t_re  = 1'b1;
                w_t_ra0 = taddr(r_item.level, w_lo_w);
                w_t_ra1 = taddr(r_item.level, w_bs_w);
            end
            S_QEL: begin
                w_e_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ready   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_m_tready && (r_state != S_QOUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_item <= i_item;
                        if (i_item.cmd == CMD_LOAD) begin
                            r_ready <= 1'b0;
                            r_cnt   <= (w_idx < CW'(MAX_ELEMENTS)) ? w_idx + CW'(1) : w_idx;
                            r_i     <= '0;
                            r_lvl   <= '0;
                            if (i_item.last) begin
                                r_state <= S_LVL0;
                            end
                        end else begin
                            r_err   <= w_q_err;
                            r_state <= w_q_err ? S_QOUT : S_QRD;
                        end
                    end
                end
                S_LVL0: begin
                    if (r_i == r_cnt - CW'(1)) begin
                        r_i    <= '0;
                        r_lvl  <= LevelW'(1);
                        r_span <= (CW+1)'(2);
                        if (r_cnt < CW'(2)) begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_BRD;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_BRD: begin
                    r_state <= S_BEL;
                end
                S_BEL: begin
                    r_a     <= w_t_rd0;
                    r_b     <= w_t_rd1;
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    if (({1'b0, r_i} + r_span) == {1'b0, r_cnt}) begin
                        r_i    <= '0;
                        r_lvl  <= r_lvl + LevelW'(1);
                        r_span <= w_nspan;
                        if ((w_nspan > {1'b0, r_cnt})
                            || (int'(r_lvl) + 1 >= TABLE_LEVELS)) begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_BRD;
                        end
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_BRD;
                    end
                end
                S_QRD: begin
                    r_state <= S_QEL;
                end
                S_QEL: begin
                    r_a     <= w_t_rd0;
                    r_b     <= w_t_rd1;
                    r_state <= S_QOUT;
                end
                S_QOUT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_err   <= r_err;
                        r_m_pos   <= r_err ? '0 : w_pick_w[PosW-1:0];
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(16-PosW){1'b0}}, r_m_pos};
    assign o_m_tuser  = r_m_err;
endmodule

@@ sv/sparse_table_range_min_index.sv @@
// Top level of the sparse-table range-minimum position block.
// Loads and queries enter a two-entry queue and are carried out in order by the
// execution unit, which owns the element memory and the position table memory.
// A load writes the element memory there; a query steps through a table read, an
// element read, a compare and the result register, each waiting on a registered
// memory read. The load flagged last starts the table build, which writes level
// zero at one entry a cycle and each of the n - 2^k + 1 entries of level k >= 1
// (n loaded elements) by a table read, an element read and a compare-and-write.
// Queries wait behind the build; the input side keeps taking items while the
// queue has room, and a finished result waits in the output register.
module sparse_table_range_min_index
    import strmi_pkg::*;
#(
    parameter int MAX_ELEMENTS = DefMaxElements,
    parameter int TABLE_LEVELS = DefTableLevels
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [55:0]   i_s_tdata,   // value[31:0], left[41:32], right[51:42], zero fill
    input  logic          i_s_tuser,   // command
    input  logic          i_s_tlast,   // is_last
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [15:0]   o_m_tdata,   // min_position[9:0], zero fill
    output logic          o_m_tuser    // range_error
);
    logic  w_item_valid;
    logic  w_pop;
    t_item w_item;

    strmi_front #(.TABLE_LEVELS(TABLE_LEVELS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .i_pop(w_pop), .o_item_valid(w_item_valid), .o_item(w_item)
    );

    strmi_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .TABLE_LEVELS(TABLE_LEVELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item_valid(w_item_valid), .i_item(w_item), .o_pop(w_pop),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );
endmodule

@@ sv/strmi_checker.sv @@
// Port-level assertions for the range-minimum position block, bound to the top level.
module strmi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[9:0] == 10'd0)
        else $error("error result carries a nonzero position");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:10] == 6'd0)
        else $error("result fill bits are not zero");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");
endmodule

bind sparse_table_range_min_index strmi_checker u_strmi_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
);
